>>> hdl/mwcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcw_pkg
// shared types, codes and helpers for the mecanum wheel command watchdog
// ----------------------------------------------------------------------------
package mwcw_pkg;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int WIDE_W     = 23;

    localparam logic [1:0] REQ_CMD  = 2'd0;
    localparam logic [1:0] REQ_STOP = 2'd1;
    localparam logic [1:0] REQ_TICK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y      = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VX    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_VY    = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TURN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_WHEEL = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MASK  = 4'd7;

    localparam logic [15:0] RST_BASE_X      = 16'd1229;
    localparam logic [15:0] RST_BASE_Y      = 16'd819;
    localparam logic [14:0] RST_LIMIT_VX    = 15'd2048;
    localparam logic [14:0] RST_LIMIT_VY    = 15'd2048;
    localparam logic [14:0] RST_LIMIT_TURN  = 15'd4096;
    localparam logic [14:0] RST_LIMIT_WHEEL = 15'd4096;
    localparam logic [15:0] RST_TIMEOUT     = 16'd300;
    localparam logic [3:0]  RST_WHEEL_MASK  = 4'hF;

    localparam logic [15:0] AGE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] base_length_x;
        logic [15:0] base_width_y;
        logic [14:0] limit_vx;
        logic [14:0] limit_vy;
        logic [14:0] limit_turn;
        logic [14:0] limit_wheel;
        logic [15:0] timeout_ms;
        logic [3:0]  wheel_enable_mask;
    } mwcw_cfg_t;

    // symmetric clamp to [-lim, lim]
    function automatic logic signed [15:0] clamp_sym(
        input logic signed [WIDE_W-1:0] v,
        input logic [14:0]              lim
    );
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        logic signed [WIDE_W-1:0] r;
        begin
            hi = signed'({{(WIDE_W-15){1'b0}}, lim});
            lo = -hi;
            if (v > hi)
            begin
                r = hi;
            end
            else if (v < lo)
            begin
                r = lo;
            end
            else
            begin
                r = v;
            end
            return r[15:0];
        end
    endfunction

endpackage

>>> hdl/mwcw_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcw_req_if
// request channel: velocity command, emergency stop or timer tick
// ----------------------------------------------------------------------------
interface mwcw_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic signed [15:0] cmd_vx;
    logic signed [15:0] cmd_vy;
    logic signed [15:0] cmd_turn;
    logic [9:0]         elapsed_ms;

    modport source (
        output valid, req_type, cmd_vx, cmd_vy, cmd_turn, elapsed_ms,
        input  ready
    );
    modport sink (
        input  valid, req_type, cmd_vx, cmd_vy, cmd_turn, elapsed_ms,
        output ready
    );
endinterface

>>> hdl/mwcw_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcw_res_if
// result channel: four wheel speeds and stop flag
// ----------------------------------------------------------------------------
interface mwcw_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] wheel_front_left;
    logic signed [15:0] wheel_front_right;
    logic signed [15:0] wheel_rear_right;
    logic signed [15:0] wheel_rear_left;
    logic               stop_flag;

    modport source (
        output valid, wheel_front_left, wheel_front_right, wheel_rear_right,
               wheel_rear_left, stop_flag,
        input  ready
    );
    modport sink (
        input  valid, wheel_front_left, wheel_front_right, wheel_rear_right,
               wheel_rear_left, stop_flag,
        output ready
    );
endinterface

>>> hdl/mwcw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcw_cfg
// configuration register file with write-only port
// ----------------------------------------------------------------------------
module mwcw_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mwcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwcw_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output mwcw_pkg::mwcw_cfg_t             cfg
);
    import mwcw_pkg::*;

    mwcw_cfg_t cfg_reg;
    mwcw_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BASE_X:      cfg_next.base_length_x     = cfg_wdata;
                CFG_BASE_Y:      cfg_next.base_width_y      = cfg_wdata;
                CFG_LIMIT_VX:    cfg_next.limit_vx          = cfg_wdata[14:0];
                CFG_LIMIT_VY:    cfg_next.limit_vy          = cfg_wdata[14:0];
                CFG_LIMIT_TURN:  cfg_next.limit_turn        = cfg_wdata[14:0];
                CFG_LIMIT_WHEEL: cfg_next.limit_wheel       = cfg_wdata[14:0];
                CFG_TIMEOUT:     cfg_next.timeout_ms        = cfg_wdata;
                CFG_WHEEL_MASK:  cfg_next.wheel_enable_mask = cfg_wdata[3:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_length_x     <= RST_BASE_X;
            cfg_reg.base_width_y      <= RST_BASE_Y;
            cfg_reg.limit_vx          <= RST_LIMIT_VX;
            cfg_reg.limit_vy          <= RST_LIMIT_VY;
            cfg_reg.limit_turn        <= RST_LIMIT_TURN;
            cfg_reg.limit_wheel       <= RST_LIMIT_WHEEL;
            cfg_reg.timeout_ms        <= RST_TIMEOUT;
            cfg_reg.wheel_enable_mask <= RST_WHEEL_MASK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/mwcw_kin.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwcw_kin
// mecanum inverse kinematics with wheel clamp and enable mask
// ----------------------------------------------------------------------------
module mwcw_kin (
    input  logic signed [15:0] vx,
    input  logic signed [15:0] vy,
    input  logic signed [15:0] turn,
    input  mwcw_pkg::mwcw_cfg_t cfg,
    output logic signed [15:0] wheel [4]
);
    import mwcw_pkg::*;

    logic [16:0]              base_sum;
    logic [15:0]              k;
    logic signed [32:0]       prod;
    logic signed [20:0]       p;
    logic signed [WIDE_W-1:0] vx_w;
    logic signed [WIDE_W-1:0] vy_w;
    logic signed [WIDE_W-1:0] p_w;
    logic signed [WIDE_W-1:0] raw [4];

    assign base_sum = {1'b0, cfg.base_length_x} + {1'b0, cfg.base_width_y};
    assign k        = base_sum[16:1];
    assign prod     = 33'(turn) * 33'(signed'({1'b0, k}));
    // arithmetic shift by 12, floor rounding
    assign p        = prod[32:12];

    assign vx_w = signed'({{(WIDE_W-16){vx[15]}}, vx});
    assign vy_w = signed'({{(WIDE_W-16){vy[15]}}, vy});
    assign p_w  = signed'({{(WIDE_W-21){p[20]}}, p});

    assign raw[0] = vx_w - vy_w - p_w;
    assign raw[1] = vx_w + vy_w + p_w;
    assign raw[2] = vx_w + vy_w - p_w;
    assign raw[3] = vx_w - vy_w + p_w;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (cfg.wheel_enable_mask[i])
            begin
                wheel[i] = clamp_sym(raw[i], cfg.limit_wheel);
            end
            else
            begin
                wheel[i] = '0;
            end
        end
    end

endmodule

>>> hdl/mecanum_wheel_command_watchdog.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecanum_wheel_command_watchdog
// holds a clamped velocity command, ages it on timer ticks, and turns it into
// four mecanum wheel speeds
// a stop or tick result is registered in the input register and then in the result register
// throughput: one transaction per cycle, set by the input and result registers
// a stalled result register holds back only items that produce a result
// reset clears the held command, valid mark and age, and loads config defaults
// ----------------------------------------------------------------------------
module mecanum_wheel_command_watchdog (
    input  logic                            clk,
    input  logic                            rst_n,
    mwcw_req_if.sink                        req,
    mwcw_res_if.source                      res,
    input  logic                            cfg_wr_en,
    input  logic [mwcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mwcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mwcw_pkg::*;

    mwcw_cfg_t cfg;

    // input register
    logic               s1_valid_reg, s1_valid_next;
    logic [1:0]         s1_type_reg;
    logic signed [15:0] s1_vx_reg;
    logic signed [15:0] s1_vy_reg;
    logic signed [15:0] s1_turn_reg;
    logic [9:0]         s1_elapsed_reg;

    // command state
    logic signed [15:0] held_vx_reg, held_vx_next;
    logic signed [15:0] held_vy_reg, held_vy_next;
    logic signed [15:0] held_turn_reg, held_turn_next;
    logic               cmd_valid_reg, cmd_valid_next;
    logic [15:0]        age_reg, age_next;

    // result register
    logic               res_valid_reg, res_valid_next;
    logic signed [15:0] res_wheel_reg [4];
    logic               res_stop_reg;

    logic               s1_has_res;
    logic               out_free;
    logic               s1_fire;
    logic               in_fire;
    logic [16:0]        age_sum;
    logic [15:0]        age_sat;
    logic               timed_out;
    logic signed [15:0] eff_vx;
    logic signed [15:0] eff_vy;
    logic signed [15:0] eff_turn;
    logic signed [15:0] kin_wheel [4];

    mwcw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mwcw_kin u_kin (
        .vx    (eff_vx),
        .vy    (eff_vy),
        .turn  (eff_turn),
        .cfg   (cfg),
        .wheel (kin_wheel)
    );

    assign s1_has_res = (s1_type_reg == REQ_STOP) || (s1_type_reg == REQ_TICK);
    assign out_free   = !res_valid_reg || res.ready;
    assign s1_fire    = s1_valid_reg && (!s1_has_res || out_free);
    assign req.ready  = !s1_valid_reg || s1_fire;
    assign in_fire    = req.valid && req.ready;

    assign age_sum   = {1'b0, age_reg} + {7'b0, s1_elapsed_reg};
    assign age_sat   = age_sum[16] ? AGE_MAX : age_sum[15:0];
    assign timed_out = (cfg.timeout_ms != '0) && cmd_valid_reg && (age_sat > cfg.timeout_ms);

    assign eff_vx   = timed_out ? '0 : held_vx_reg;
    assign eff_vy   = timed_out ? '0 : held_vy_reg;
    assign eff_turn = timed_out ? '0 : held_turn_reg;

    always_comb
    begin
        s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
        res_valid_next = (s1_fire && s1_has_res) || (res_valid_reg && !res.ready);
        held_vx_next   = held_vx_reg;
        held_vy_next   = held_vy_reg;
        held_turn_next = held_turn_reg;
        cmd_valid_next = cmd_valid_reg;
        age_next       = age_reg;
        if (s1_fire)
        begin
            case (s1_type_reg)
                REQ_CMD:
                begin
                    held_vx_next   = clamp_sym(WIDE_W'(s1_vx_reg), cfg.limit_vx);
                    held_vy_next   = clamp_sym(WIDE_W'(s1_vy_reg), cfg.limit_vy);
                    held_turn_next = clamp_sym(WIDE_W'(s1_turn_reg), cfg.limit_turn);
                    cmd_valid_next = 1'b1;
                    age_next       = '0;
                end
                REQ_STOP:
                begin
                    held_vx_next   = '0;
                    held_vy_next   = '0;
                    held_turn_next = '0;
                    cmd_valid_next = 1'b0;
                end
                REQ_TICK:
                begin
                    age_next = age_sat;
                    if (timed_out)
                    begin
                        held_vx_next   = '0;
                        held_vy_next   = '0;
                        held_turn_next = '0;
                        cmd_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    age_next = age_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            held_vx_reg   <= '0;
            held_vy_reg   <= '0;
            held_turn_reg <= '0;
            cmd_valid_reg <= 1'b0;
            age_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            held_vx_reg   <= held_vx_next;
            held_vy_reg   <= held_vy_next;
            held_turn_reg <= held_turn_next;
            cmd_valid_reg <= cmd_valid_next;
            age_reg       <= age_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_type_reg    <= req.req_type;
            s1_vx_reg      <= req.cmd_vx;
            s1_vy_reg      <= req.cmd_vy;
            s1_turn_reg    <= req.cmd_turn;
            s1_elapsed_reg <= req.elapsed_ms;
        end
        if (s1_fire && s1_has_res)
        begin
            res_stop_reg <= (s1_type_reg == REQ_STOP);
            for (int i = 0; i < 4; i++)
            begin
                res_wheel_reg[i] <= (s1_type_reg == REQ_STOP) ? '0 : kin_wheel[i];
            end
        end
    end

    assign res.valid             = res_valid_reg;
    assign res.wheel_front_left  = res_wheel_reg[0];
    assign res.wheel_front_right = res_wheel_reg[1];
    assign res.wheel_rear_right  = res_wheel_reg[2];
    assign res.wheel_rear_left   = res_wheel_reg[3];
    assign res.stop_flag         = res_stop_reg;

endmodule
